/* rtl/tmwf_pkg.sv */
// Shared constants for the trimmed-mean window filter.
// Depends on nothing; imported by trimmed_mean_window_filter_top.
package tmwf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int WEIGHT_W = 25;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from the word-aligned part of the address.
    localparam logic REG_TARE_OFFSET = 1'b0;

endpackage

/* rtl/trimmed_mean_window_filter_top.sv */
// Trimmed-mean window filter top level: ring buffer, rank-by-compare sequencer,
// reciprocal-multiply mean and tare subtraction. Depends on tmwf_pkg.
// During the first fill an accepted word passes through FINISH to the output registers; the word
// that completes the ring and every later word are first ranked by the serial scan (LOAD, KEYCAP,
// SCAN and DECIDE for each entry, then DIV and FINISH). A new word is taken only in IDLE, once the
// previous result has been loaded; FINISH holds while a finished result waits to be taken.
// Reset (rst_n, asynchronous, low) clears tare_offset, write position and fill flag.
module trimmed_mean_window_filter_top #(
    parameter int WINDOW = 8,
    parameter int DROP   = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tmwf_pkg::PADDR_W-1:0]          paddr,
    input  logic [tmwf_pkg::PDATA_W-1:0]          pwdata,
    output logic [tmwf_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic [tmwf_pkg::SAMPLE_W-1:0]         sample,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [tmwf_pkg::SAMPLE_W-1:0]         filtered,
    output logic signed [tmwf_pkg::WEIGHT_W-1:0]  filtered_weight,
    output logic signed [tmwf_pkg::WEIGHT_W-1:0]  raw_weight,
    output logic                                  window_full
);

    import tmwf_pkg::*;

    localparam int IDX_W     = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 2);
    localparam int KEEP_DROP = (2 * DROP < WINDOW) ? DROP : (WINDOW - 1) / 2;
    localparam int KEEP_N    = WINDOW - 2 * KEEP_DROP;
    localparam int SUM_W     = SAMPLE_W + IDX_W;
    localparam int SHIFT_W   = SUM_W + $clog2(KEEP_N);
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT_W) + 64'(KEEP_N - 1)) / 64'(KEEP_N);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_KEYCAP,
        ST_SCAN,
        ST_DECIDE,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [SAMPLE_W-1:0]    ring_mem [WINDOW];
    logic [SAMPLE_W-1:0]    rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       pj_reg;
    logic [IDX_W-1:0]       wp_reg;
    logic                   filled_reg;
    logic [SAMPLE_W-1:0]    tare_reg;
    logic [CNT_W-1:0]       i_reg;
    logic [CNT_W-1:0]       j_reg;
    logic [CNT_W-1:0]       rank_reg;
    logic [SAMPLE_W-1:0]    key_reg;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_add;
    logic [SUM_W-1:0]       dq_reg;
    logic [PROD_W-1:0]      product;
    logic                   less;
    logic                   keep;
    logic                   accept;
    logic                   wrap;
    logic                   out_load;
    logic                   cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TARE_OFFSET);
    assign prdata    = (paddr[2] == REG_TARE_OFFSET)
                       ? {{(PDATA_W-SAMPLE_W){1'b0}}, tare_reg} : '0;

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign wrap         = (wp_reg == IDX_W'(WINDOW - 1));
    assign out_load     = (state_reg == ST_FINISH) && (!result_valid || result_ready);

    // An entry ranks below the key if smaller, or equal and at a lower index,
    // so every entry gets a distinct rank and ties resolve like a stable sort.
    assign less = (rd_data_reg < key_reg) || ((rd_data_reg == key_reg) && (pj_reg < i_reg[IDX_W-1:0]));
    assign keep = (rank_reg >= CNT_W'(KEEP_DROP)) && (rank_reg < CNT_W'(WINDOW - KEEP_DROP));
    assign sum_add = sum_reg + (keep ? {{(SUM_W-SAMPLE_W){1'b0}}, key_reg} : '0);

    // The kept count is constant, so the mean is a multiply by its rounded-up reciprocal.
    // With the shift set to the sum width plus the ceiling log2 of the count the quotient is exact.
    assign product = PROD_W'(sum_reg) * PROD_W'(RECIP[RECIP_W-1:0]);

    always_comb
    begin
        rd_addr = '0;
        case (state_reg)
            ST_LOAD:   rd_addr = i_reg[IDX_W-1:0];
            ST_KEYCAP: rd_addr = '0;
            ST_SCAN:   rd_addr = (j_reg < CNT_W'(WINDOW)) ? j_reg[IDX_W-1:0] : '0;
            default:   rd_addr = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = (wrap || filled_reg) && wrap ? ST_LOAD
                                               : (filled_reg ? ST_LOAD : ST_FINISH);
            ST_LOAD:   state_next = ST_KEYCAP;
            ST_KEYCAP: state_next = ST_SCAN;
            ST_SCAN:   if (pj_reg == IDX_W'(WINDOW - 1)) state_next = ST_DECIDE;
            ST_DECIDE: state_next = (i_reg == CNT_W'(WINDOW - 1)) ? ST_DIV : ST_LOAD;
            ST_DIV:    state_next = ST_FINISH;
            ST_FINISH: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Ring storage with registered read data.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[wp_reg] <= sample;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            filled_reg   <= 1'b0;
            tare_reg     <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            rank_reg     <= '0;
            result_valid <= 1'b0;
            window_full  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                tare_reg <= pwdata[SAMPLE_W-1:0];
            end
            if (accept)
            begin
                wp_reg <= wrap ? '0 : wp_reg + 1'b1;
                if (wrap)
                begin
                    filled_reg <= 1'b1;
                end
                i_reg <= '0;
            end
            case (state_reg)
                ST_KEYCAP:
                begin
                    j_reg    <= CNT_W'(1);
                    rank_reg <= '0;
                end
                ST_SCAN:
                begin
                    if (j_reg != CNT_W'(WINDOW))
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    rank_reg <= rank_reg + CNT_W'(less);
                end
                ST_DECIDE:
                begin
                    i_reg <= i_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
            if (out_load)
            begin
                result_valid <= 1'b1;
                window_full  <= filled_reg;
            end
            else if (result_ready)
            begin
                result_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; no reset needed.
    always_ff @(posedge clk)
    begin
        pj_reg <= rd_addr;
        if (accept)
        begin
            sample_reg <= sample;
            sum_reg    <= '0;
            dq_reg     <= {{(SUM_W-SAMPLE_W){1'b0}}, sample};
        end
        case (state_reg)
            ST_KEYCAP:
            begin
                key_reg <= rd_data_reg;
            end
            ST_DECIDE:
            begin
                sum_reg <= sum_add;
            end
            ST_DIV:
            begin
                dq_reg <= {{(SUM_W-SAMPLE_W){1'b0}}, product[SHIFT_W +: SAMPLE_W]};
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            filtered        <= dq_reg[SAMPLE_W-1:0];
            filtered_weight <= $signed({1'b0, dq_reg[SAMPLE_W-1:0]} - {1'b0, tare_reg});
            raw_weight      <= $signed({1'b0, sample_reg} - {1'b0, tare_reg});
        end
    end

    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !sample_ready)
        else $error("sample_ready stayed high after a word was accepted");

    a_wp_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg < IDX_W'(WINDOW - 1) || wp_reg == IDX_W'(WINDOW - 1))
        else $error("write position left the ring");

    a_full_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && window_full |-> filled_reg)
        else $error("window_full reported before the ring filled");

    a_sort_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> filled_reg)
        else $error("ranking started before the ring filled");

    a_div_after_all_keys : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && $past(state_reg) == ST_DECIDE |-> i_reg == CNT_W'(WINDOW))
        else $error("division started before every entry was ranked");

endmodule

/* dv/trimmed_mean_window_filter_top_test.sv */
// Self-checking testbench for trimmed_mean_window_filter_top: directed vectors, then random
// load-cell sample streams with fixed and random tare settings, checked against an in-bench filter model.
// Depends on tmwf_pkg and the RTL top level only.
module trimmed_mean_window_filter_top_test;

    localparam int WINDOW = 8;
    localparam int DROP   = 2;
    localparam int TRIM   = (2 * DROP < WINDOW) ? DROP : (WINDOW - 1) / 2;
    localparam int SW     = tmwf_pkg::SAMPLE_W;
    localparam int WW     = tmwf_pkg::WEIGHT_W;

    localparam int SETTLE_CYCLES  = 2 * (WINDOW * (WINDOW + 3) + 32);
    localparam int HOLD_CYCLES    = 600;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 305;
    localparam int TIMEOUT_CYCLES = 1200000;

    typedef struct packed {
        logic [SW-1:0] filtered;
        logic [WW-1:0] filtered_weight;
        logic [WW-1:0] raw_weight;
        logic          window_full;
    } result_t;

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          retare;
        logic [SW-1:0] tare;
        logic          pinned;
        result_t       want;
    } vector_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [tmwf_pkg::PADDR_W-1:0]  paddr;
    logic [tmwf_pkg::PDATA_W-1:0]  pwdata;
    logic [tmwf_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          sample_valid;
    logic                          sample_ready;
    logic [SW-1:0]                 sample;
    logic                          result_valid;
    logic                          result_ready;
    logic [SW-1:0]                 filtered;
    logic signed [WW-1:0]          filtered_weight;
    logic signed [WW-1:0]          raw_weight;
    logic                          window_full;

    // Filter model state.
    logic [SW-1:0] window_ring [WINDOW];
    int            ring_wr_pos = 0;
    bit            ring_wrapped = 1'b0;
    logic [SW-1:0] tare_setting = '0;

    result_t   expected_q [$];
    vector_t   directed_vectors [$];
    bit        pin_next = 1'b0;
    result_t   pinned_result = '0;
    bit        source_idle = 1'b0;
    bit        sink_idle = 1'b0;
    int        sink_hold_cycles = 0;
    int        samples_taken = 0;
    int        results_checked = 0;
    int        tare_writes = 0;
    int        mismatch_count = 0;

    trimmed_mean_window_filter_top #(
        .WINDOW (WINDOW),
        .DROP   (DROP)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .filtered        (filtered),
        .filtered_weight (filtered_weight),
        .raw_weight      (raw_weight),
        .window_full     (window_full)
    );

    always #1 clk = ~clk;

    initial
    begin
        #(2 * TIMEOUT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Writes the sample into the ring and works out the filter outputs for it.
    function automatic result_t filter_sample(input logic [SW-1:0] s);
        logic [SW-1:0] sorted [WINDOW];
        logic [SW-1:0] key;
        logic [63:0]   kept_sum;
        logic [SW-1:0] mean;
        result_t       r;
        int            j;

        window_ring[ring_wr_pos] = s;
        ring_wr_pos++;
        if (ring_wr_pos >= WINDOW)
        begin
            ring_wr_pos  = 0;
            ring_wrapped = 1'b1;
        end

        mean = s;
        if (ring_wrapped)
        begin
            for (int i = 0; i < WINDOW; i++)
                sorted[i] = window_ring[i];
            for (int i = 1; i < WINDOW; i++)
            begin
                key = sorted[i];
                j = i;
                while (j > 0 && sorted[j - 1] > key)
                begin
                    sorted[j] = sorted[j - 1];
                    j--;
                end
                sorted[j] = key;
            end
            kept_sum = '0;
            for (int i = TRIM; i < WINDOW - TRIM; i++)
                kept_sum += 64'(sorted[i]);
            mean = SW'(kept_sum / 64'(WINDOW - 2 * TRIM));
        end

        r.filtered        = mean;
        r.filtered_weight = {1'b0, mean} - {1'b0, tare_setting};
        r.raw_weight      = {1'b0, s} - {1'b0, tare_setting};
        r.window_full     = ring_wrapped;
        return r;
    endfunction

    function automatic void add_vector(input logic [SW-1:0] s, input logic retare,
                                       input logic [SW-1:0] tare, input logic pinned,
                                       input result_t want);
        vector_t v;
        v.sample = s;
        v.retare = retare;
        v.tare   = tare;
        v.pinned = pinned;
        v.want   = want;
        directed_vectors.push_back(v);
    endfunction

    // Input side prediction and output side checking, both at the rising edge.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n === 1'b1 && sample_valid && sample_ready)
        begin
            want = filter_sample(sample);
            if (pin_next)
                want = pinned_result;
            expected_q.push_back(want);
            samples_taken++;
        end
        if (rst_n === 1'b1 && result_valid && result_ready)
        begin
            got = {filtered, filtered_weight, raw_weight, window_full};
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: filtered %h", got.filtered);
                mismatch_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                results_checked++;
                if (got.filtered !== want.filtered)
                begin
                    $error("filtered: expected %h, got %h", want.filtered, got.filtered);
                    mismatch_count++;
                end
                if (got.filtered_weight !== want.filtered_weight)
                begin
                    $error("filtered_weight: expected %h, got %h",
                           want.filtered_weight, got.filtered_weight);
                    mismatch_count++;
                end
                if (got.raw_weight !== want.raw_weight)
                begin
                    $error("raw_weight: expected %h, got %h", want.raw_weight, got.raw_weight);
                    mismatch_count++;
                end
                if (got.window_full !== want.window_full)
                begin
                    $error("window_full: expected %b, got %b", want.window_full, got.window_full);
                    mismatch_count++;
                end
            end
        end
    end

    // Result receiver: random idle before each word, plus an optional long hold-off.
    initial
    begin
        int gap;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (sink_hold_cycles != 0)
            begin
                result_ready = 1'b0;
                repeat (sink_hold_cycles) @(negedge clk);
                sink_hold_cycles = 0;
            end
            gap = sink_idle ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                result_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready = 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    task automatic send_sample(input logic [SW-1:0] value, input bit pin, input result_t want);
        int gap;
        gap = source_idle ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample        = value;
        pin_next      = pin;
        pinned_result = want;
        sample_valid  = 1'b1;
        do @(posedge clk); while (!sample_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        sample_valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    // Writes tare_offset through the register port and reads it back.
    task automatic write_tare(input logic [SW-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = tmwf_pkg::PADDR_W'(4 * tmwf_pkg::REG_TARE_OFFSET);
        pwdata  = tmwf_pkg::PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        tare_setting = value;
        tare_writes++;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[SW-1:0] !== value)
        begin
            $error("tare_offset readback: expected %h, got %h", value, prdata[SW-1:0]);
            mismatch_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial
    begin
        logic [SW-1:0] value;
        logic [SW-1:0] base;
        logic [SW-1:0] last_value;
        logic [SW-1:0] tare_value;
        int            kind;
        int            span;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        sample_valid = 1'b0;
        sample       = '0;
        for (int i = 0; i < WINDOW; i++)
            window_ring[i] = '0;

        // First fill: the output follows the sample, weights track each tare change.
        add_vector(24'h000000, 0, 24'h0, 1, {24'h000000, 25'h0000000, 25'h0000000, 1'b0});
        add_vector(24'hFFFFFF, 0, 24'h0, 1, {24'hFFFFFF, 25'h0FFFFFF, 25'h0FFFFFF, 1'b0});
        add_vector(24'h000000, 1, 24'hFFFFFF, 1, {24'h000000, 25'h1000001, 25'h1000001, 1'b0});
        add_vector(24'hFFFFFF, 0, 24'h0, 1, {24'hFFFFFF, 25'h0000000, 25'h0000000, 1'b0});
        add_vector(24'h7FFFFF, 1, 24'h800000, 1, {24'h7FFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 1'b0});
        add_vector(24'h000001, 0, 24'h0, 0, '0);
        add_vector(24'h555555, 1, 24'h000000, 1, {24'h555555, 25'h0555555, 25'h0555555, 1'b0});
        // This word completes the first pass around the ring.
        add_vector(24'hAAAAAA, 0, 24'h0, 0, '0);
        for (int i = 0; i < WINDOW - 1; i++)
            add_vector(24'hFFFFFF, 0, 24'h0, 0, '0);
        add_vector(24'hFFFFFF, 0, 24'h0, 1, {24'hFFFFFF, 25'h0FFFFFF, 25'h0FFFFFF, 1'b1});
        // A single low outlier is trimmed away; raw weight hits its negative extreme.
        add_vector(24'h000000, 1, 24'hFFFFFF, 1, {24'hFFFFFF, 25'h0000000, 25'h1000001, 1'b1});
        add_vector(24'h000001, 0, 24'h0, 0, '0);
        add_vector(24'h000002, 0, 24'h0, 0, '0);
        add_vector(24'h000003, 0, 24'h0, 0, '0);
        add_vector(24'h000004, 1, 24'h000000, 0, '0);
        add_vector(24'h123456, 0, 24'h0, 0, '0);
        add_vector(24'hFEDCBA, 0, 24'h0, 0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        source_idle = 1'b1;
        sink_idle   = 1'b1;
        foreach (directed_vectors[i])
        begin
            if (directed_vectors[i].retare)
            begin
                drain_results();
                write_tare(directed_vectors[i].tare);
            end
            send_sample(directed_vectors[i].sample, directed_vectors[i].pinned,
                        directed_vectors[i].want);
        end
        drain_results();

        last_value = '0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       tare_value = 24'hFFFFFF;
                1:       tare_value = 24'h000000;
                3:       tare_value = 24'h800000;
                default: tare_value = SW'($urandom);
            endcase
            write_tare(tare_value);
            source_idle = (phase != 0 && phase != 3);
            sink_idle   = (phase != 0 && phase != 4);
            // The receiver holds off while samples keep coming, so the input stalls.
            if (phase == 2)
                sink_hold_cycles = HOLD_CYCLES;

            base = SW'($urandom);
            span = 1 << $urandom_range(0, 16);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Mostly a steady load with converter noise, with steps, spikes and rails.
                if ($urandom_range(0, 63) == 0)
                begin
                    base = SW'($urandom);
                    span = 1 << $urandom_range(0, 16);
                end
                kind = $urandom_range(0, 9);
                if (kind <= 3)
                    value = base + SW'($urandom_range(0, 2 * span)) - SW'(span);
                else if (kind == 4)
                    value = ($urandom_range(0, 1) != 0) ? '1 : '0;
                else if (kind == 5)
                    value = last_value;
                else
                    value = SW'($urandom);
                send_sample(value, 1'b0, '0);
                last_value = value;
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Run covered %0d samples (%0d directed) and checked %0d filtered words,",
                 samples_taken, directed_vectors.size(), results_checked);
        $display("across %0d tare settings, random idling on both sides and a %0d-cycle stall.",
                 tare_writes, HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tmwf_pkg.sv
rtl/trimmed_mean_window_filter_top.sv
dv/trimmed_mean_window_filter_top_test.sv
